/* hdl/lpht_pkg.sv */
// Package for the linear probing hash table: item types, status and state codes.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    localparam int DEFAULT_DEPTH = 1024;
    localparam int KEY_W         = 64;
    localparam int SCORE_W       = 32;
    localparam int COUNT_OUT_W   = 11;
    localparam int MOD_BITS      = 8;
    localparam int MOD_STEPS     = KEY_W / MOD_BITS;
    localparam int MOD_CNT_W     = $clog2(MOD_STEPS);
    // The queue depth must stay a power of two so the pointers wrap naturally.
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef struct packed {
        logic                      cmd;
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] new_score;
    } in_item_t;

    typedef struct packed {
        status_t                   status;
        logic signed [SCORE_W-1:0] score_out;
        logic [COUNT_OUT_W-1:0]    entry_count;
    } out_item_t;

    typedef struct packed {
        logic                      valid;
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MOD,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_PROBE,
        BK_DONE
    } back_state_t;

    localparam int ITEM_W = $bits(in_item_t);

endpackage

`default_nettype wire

/* hdl/linear_probe_hash_table.sv */
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | lpht_pkg::in_item_t (cmd, key, new_score)
// rsp     | out       | rsp_valid, rsp_stall | lpht_pkg::out_item_t (status, score_out, entry_count)
//
// After reset a clearing pass marks every slot empty, and req_stall stays high
// throughout. The front end holds one item at a time and stalls new requests until it
// has pushed it; its home slot is the low key bits for a power-of-two depth, else the
// output of the 8-bit-per-cycle modulo unit. The probe engine reads one slot per cycle
// from its single-port slot memory; an item needs up to TABLE_DEPTH probes on a full table.
// Two items wait in the queue between them, and the result register lets the next item
// probe while a result sits stalled.
// Top level of the hash table; depends on lpht_pkg, lpht_front, lpht_queue, lpht_back.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = lpht_pkg::DEFAULT_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire lpht_pkg::in_item_t  req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output lpht_pkg::out_item_t      rsp
);
    import lpht_pkg::*;

    localparam int Q_W = ITEM_W + $clog2(TABLE_DEPTH);

    logic           ready;
    logic           push_valid, q_full, q_pop, q_empty;
    logic [Q_W-1:0] push_data, q_data;

    lpht_front #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (ready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .push_valid(push_valid),
        .push_full (q_full),
        .push_data (push_data)
    );

    lpht_queue #(
        .DATA_W(Q_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_data(push_data),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (q_data),
        .empty    (q_empty)
    );

    lpht_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ready    (ready),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_data   (q_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

/* hdl/lpht_front.sv */
// Front end: takes an item and works out its home slot, the key modulo the depth.
// Depends on lpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpht_front #(
    parameter int TABLE_DEPTH = lpht_pkg::DEFAULT_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              enable,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire lpht_pkg::in_item_t                req,
    output logic                                   push_valid,
    input  wire logic                              push_full,
    output logic [lpht_pkg::ITEM_W+$clog2(TABLE_DEPTH)-1:0] push_data
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam bit DEPTH_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(TABLE_DEPTH);

    front_state_t           state_reg, state_next;
    in_item_t               item_reg, item_next;
    logic [KEY_W-1:0]       shift_reg, shift_next;
    logic [IDX_W:0]         rem_reg, rem_next;
    logic [MOD_CNT_W-1:0]   step_reg, step_next;
    logic [IDX_W:0]         rem_step;
    logic [IDX_W-1:0]       home;

    always_comb
    begin
        rem_step = rem_reg;
        for (int j = 0; j < MOD_BITS; j++)
        begin
            rem_step = {rem_step[IDX_W-1:0], shift_reg[KEY_W-1-j]};
            if (rem_step >= DEPTH_C)
            begin
                rem_step = rem_step - DEPTH_C;
            end
        end
    end

    assign home = DEPTH_POW2 ? item_reg.key[IDX_W-1:0] : rem_reg[IDX_W-1:0];
    assign push_data = {item_reg, home};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        push_valid = 1'b0;
        req_stall  = (state_reg != FR_IDLE) || !enable;
        unique case (state_reg)
            FR_IDLE:
            begin
                if (req_valid && enable)
                begin
                    item_next  = req;
                    shift_next = req.key;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = DEPTH_POW2 ? FR_PUSH : FR_MOD;
                end
            end
            FR_MOD:
            begin
                rem_next   = rem_step;
                shift_next = shift_reg << MOD_BITS;
                step_next  = step_reg + 1'b1;
                if (step_reg == MOD_CNT_W'(MOD_STEPS - 1))
                begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                push_valid = 1'b1;
                if (!push_full)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/lpht_queue.sv */
// Short queue between the front end and the probe engine.
// Depends on lpht_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module lpht_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output logic                   empty
);
    import lpht_pkg::*;

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full     = fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign empty    = fill_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/lpht_back.sv */
// Probe engine: slot memory, clearing pass, linear probe and result register.
// Depends on lpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpht_back #(
    parameter int TABLE_DEPTH = lpht_pkg::DEFAULT_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    output logic                                   ready,
    input  wire logic                              q_empty,
    output logic                                   q_pop,
    input  wire logic [lpht_pkg::ITEM_W+$clog2(TABLE_DEPTH)-1:0] q_data,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output lpht_pkg::out_item_t                    rsp
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  probe_cnt_reg, probe_cnt_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    in_item_t          cur_reg, cur_next;
    out_item_t         res_reg, res_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    in_item_t          q_item;
    logic [IDX_W-1:0]  q_home;
    logic              rd_en, wr_en;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    entry_t            wr_data;
    logic              hit, out_free;
    logic signed [SCORE_W-1:0] ins_score;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext, count_inc_ext;

    assign q_item        = in_item_t'(q_data[ITEM_W+IDX_W-1:IDX_W]);
    assign q_home        = q_data[IDX_W-1:0];
    assign hit           = rd_data_reg.valid && (rd_data_reg.key == cur_reg.key);
    assign out_free      = !out_valid_reg || !rsp_stall;
    assign ins_score     = cur_reg.cmd ? cur_reg.new_score : '0;
    assign count_ext     = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign count_inc_ext = {{COUNT_OUT_W{1'b0}}, count_reg + 1'b1};
    assign ready         = state_reg != BK_CLEAR;
    assign rsp_valid     = out_valid_reg;
    assign rsp           = out_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        probe_cnt_reg <= probe_cnt_next;
        cur_reg       <= cur_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        pos_next       = pos_reg;
        probe_cnt_next = probe_cnt_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = q_home;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = '{valid: 1'b1, key: cur_reg.key, score: ins_score};
        unique case (state_reg)
            BK_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_data      = '{valid: 1'b0, key: '0, score: '0};
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop          = 1'b1;
                    rd_en          = 1'b1;
                    cur_next       = q_item;
                    pos_next       = q_home;
                    probe_cnt_next = '0;
                    state_next     = BK_PROBE;
                end
            end
            BK_PROBE:
            begin
                res_next.status      = ST_FOUND;
                res_next.score_out   = '0;
                res_next.entry_count = count_ext[COUNT_OUT_W-1:0];
                if (!rd_data_reg.valid)
                begin
                    wr_en                = 1'b1;
                    count_next           = count_reg + 1'b1;
                    res_next.status      = ST_INSERTED;
                    res_next.score_out   = ins_score;
                    res_next.entry_count = count_inc_ext[COUNT_OUT_W-1:0];
                    state_next           = BK_DONE;
                end
                else if (hit)
                begin
                    wr_en              = cur_reg.cmd;
                    wr_data            = '{valid: 1'b1, key: cur_reg.key,
                                           score: cur_reg.new_score};
                    res_next.score_out = cur_reg.cmd ? cur_reg.new_score
                                                     : rd_data_reg.score;
                    state_next         = BK_DONE;
                end
                else if (probe_cnt_reg == LAST_IDX)
                begin
                    res_next.status = ST_FULL;
                    state_next      = BK_DONE;
                end
                else
                begin
                    pos_next       = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    rd_en          = 1'b1;
                    rd_addr        = pos_next;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    if (!q_empty)
                    begin
                        q_pop          = 1'b1;
                        rd_en          = 1'b1;
                        cur_next       = q_item;
                        pos_next       = q_home;
                        probe_cnt_next = '0;
                        state_next     = BK_PROBE;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/lpht_checker.sv */
// Port-level checks for the hash table, attached to the top level by bind.
// Depends on lpht_pkg and linear_probe_hash_table.
`timescale 1ns / 1ps
`default_nettype none

module lpht_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_stall,
    input wire lpht_pkg::in_item_t  req,
    input wire logic                rsp_valid,
    input wire logic                rsp_stall,
    input wire lpht_pkg::out_item_t rsp
);
    import lpht_pkg::*;

    // The table is cleared after reset, so no item may enter right away.
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> req_stall)
        else $error("item accepted before the clearing pass");

    a_no_rsp_in_reset: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("result shown during reset");

    a_full_score_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL) |-> rsp.score_out == '0)
        else $error("full result with a nonzero score");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

`default_nettype wire
